// ----- rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// spq_pkg
// Shared types and constants for the stable sorted priority queue.
// ----------------------------------------------------------------------------
package spq_pkg;

	localparam int QUEUE_DEPTH = 16;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);

	localparam logic       OP_INSERT = 1'b0;
	localparam logic       OP_REMOVE = 1'b1;

	localparam logic [1:0] ST_OK    = 2'd0;
	localparam logic [1:0] ST_EMPTY = 2'd1;
	localparam logic [1:0] ST_FULL  = 2'd2;

	typedef struct packed {
		logic        valid;
		logic [15:0] id;
		logic [7:0]  pri;
		logic [31:0] arr;
	} entry_t;

	typedef struct packed {
		logic        push;
		logic        pop;
		logic [15:0] id;
		logic [7:0]  pri;
		logic [31:0] arr;
	} cell_ctl_t;

endpackage

// ----- rtl/spq_cell.sv -----
// ----------------------------------------------------------------------------
// spq_cell
// One slot of the sorted chain: holds, takes the new entry, or shifts.
// ----------------------------------------------------------------------------
module spq_cell (
	input  logic               clk,
	input  logic               arst_n,
	input  spq_pkg::cell_ctl_t ctl,
	input  spq_pkg::entry_t    left,
	input  logic               left_sel,
	input  spq_pkg::entry_t    right,
	output spq_pkg::entry_t    slot,
	output logic               sel
);

	logic        valid_q;
	logic [15:0] id_q;
	logic [7:0]  pri_q;
	logic [31:0] arr_q;

	// insertion point lies at or before this slot
	assign sel = !valid_q || (pri_q > ctl.pri);

	assign slot.valid = valid_q;
	assign slot.id    = id_q;
	assign slot.pri   = pri_q;
	assign slot.arr   = arr_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctl.pop) begin
			valid_q <= right.valid;
		end else if (ctl.push) begin
			if (left_sel) begin
				valid_q <= left.valid;
			end else if (sel) begin
				valid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.pop) begin
			id_q  <= right.id;
			pri_q <= right.pri;
			arr_q <= right.arr;
		end else if (ctl.push) begin
			if (left_sel) begin
				id_q  <= left.id;
				pri_q <= left.pri;
				arr_q <= left.arr;
			end else if (sel) begin
				id_q  <= ctl.id;
				pri_q <= ctl.pri;
				arr_q <= ctl.arr;
			end
		end
	end

endmodule

// ----- rtl/stable_priority_io_queue_top.sv -----
// ----------------------------------------------------------------------------
// stable_priority_io_queue_top
// Stable sorted priority queue built as a shifting chain of slot cells.
// ----------------------------------------------------------------------------
//  channel   handshake        fields
//  request   start / busy     operation, entry_id, priority_req, current_time
//  result    done (strobe)    status, head_id, head_priority, head_arrival,
//                             occupancy, is_empty
//
//  Each request is taken when start is high; every cell compares against the new
//  priority in parallel and the chain shifts in that same edge. The result is
//  strobed on done the cycle after start. busy stays low, so a request may be
//  issued every cycle. Reset empties the queue; the receiver cannot stall.
// ----------------------------------------------------------------------------
module stable_priority_io_queue_top (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        start,
	output logic        busy,
	input  logic        operation,
	input  logic [15:0] entry_id,
	input  logic [7:0]  priority_req,
	input  logic [31:0] current_time,
	output logic        done,
	output logic [1:0]  status,
	output logic [15:0] head_id,
	output logic [7:0]  head_priority,
	output logic [31:0] head_arrival,
	output logic [4:0]  occupancy,
	output logic        is_empty
);

	localparam int N = spq_pkg::QUEUE_DEPTH;

	spq_pkg::entry_t    slots [N];
	logic               sels  [N];
	spq_pkg::cell_ctl_t ctl;

	logic                    req;
	logic                    empty;
	logic                    full;
	logic [spq_pkg::CNT_W-1:0] count_q;
	logic [spq_pkg::CNT_W-1:0] count_nxt;
	logic                    done_q;
	logic [1:0]              status_q;
	logic [15:0]             head_id_q;
	logic [7:0]              head_pri_q;
	logic [31:0]             head_arr_q;

	assign busy  = 1'b0;
	assign req   = start && !busy;
	assign empty = !slots[0].valid;
	assign full  = slots[N-1].valid;

	assign ctl.push = req && (operation == spq_pkg::OP_INSERT) && !full;
	assign ctl.pop  = req && (operation == spq_pkg::OP_REMOVE) && !empty;
	assign ctl.id   = entry_id;
	assign ctl.pri  = priority_req;
	assign ctl.arr  = current_time;

	for (genvar i = 0; i < N; i++) begin : g_cell
		spq_pkg::entry_t left_e;
		spq_pkg::entry_t right_e;
		logic            left_s;

		if (i == 0) begin : g_first
			assign left_e = '0;
			assign left_s = 1'b0;
		end else begin : g_mid
			assign left_e = slots[i-1];
			assign left_s = sels[i-1];
		end

		if (i == N - 1) begin : g_last
			assign right_e = '0;
		end else begin : g_inner
			assign right_e = slots[i+1];
		end

		spq_cell u_cell (
			.clk      (clk),
			.arst_n   (arst_n),
			.ctl      (ctl),
			.left     (left_e),
			.left_sel (left_s),
			.right    (right_e),
			.slot     (slots[i]),
			.sel      (sels[i])
		);
	end

	always_comb begin
		count_nxt = count_q;
		if (ctl.push) begin
			count_nxt = count_q + 1'b1;
		end else if (ctl.pop) begin
			count_nxt = count_q - 1'b1;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			done_q  <= 1'b0;
		end else begin
			count_q <= count_nxt;
			done_q  <= req;
		end
	end

	always_ff @(posedge clk) begin
		if (req) begin
			status_q   <= spq_pkg::ST_OK;
			head_id_q  <= '0;
			head_pri_q <= '0;
			head_arr_q <= '0;
			if (operation == spq_pkg::OP_INSERT) begin
				if (full) begin
					status_q <= spq_pkg::ST_FULL;
				end
			end else if (empty) begin
				status_q <= spq_pkg::ST_EMPTY;
			end else begin
				head_id_q  <= slots[0].id;
				head_pri_q <= slots[0].pri;
				head_arr_q <= slots[0].arr;
			end
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign head_id       = head_id_q;
	assign head_priority = head_pri_q;
	assign head_arrival  = head_arr_q;
	assign occupancy     = 5'(count_q);
	assign is_empty      = (count_q == '0);

endmodule
